// File: hdl/framed_servo_pulse_generator_macros.svh
// assertion macros for the framed servo pulse generator
`ifndef FRAMED_SERVO_PULSE_GENERATOR_MACROS_SVH
`define FRAMED_SERVO_PULSE_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS
`define FSPG_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("fspg assertion failed");
`define FSPG_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("fspg forbidden condition");
`else
`define FSPG_ASSERT(lbl, prop)
`define FSPG_ASSERT_NEVER(lbl, cond)
`endif

`endif

// File: hdl/fspg_pkg.sv
// package: constants, codes, types and the position clamp function of the framed servo pulse generator
package fspg_pkg;

	localparam int FRAME_LEN     = 32;
	localparam int HIGH_PRESCALE = 8;
	localparam int LOW_PRESCALE  = 64;

	localparam int FRAME_W   = $clog2(FRAME_LEN);
	localparam int PRESC_MAX = (HIGH_PRESCALE > LOW_PRESCALE) ? HIGH_PRESCALE : LOW_PRESCALE;
	localparam int PRESC_W   = (PRESC_MAX > 2) ? $clog2(PRESC_MAX) : 1;

	localparam int DATA_W = 32;
	localparam int ADDR_W = 5;

	typedef logic [FRAME_W-1:0] frame_idx_t;
	typedef logic [FRAME_W:0]   frame_cnt_t;
	typedef logic [PRESC_W-1:0] presc_t;
	typedef logic [PRESC_W:0]   pdiv_t;
	typedef logic [15:0]        word_t;
	typedef logic [7:0]         byte_t;
	typedef logic [1:0]         psel_code_t;
	typedef logic [2:0]         reg_idx_t;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam psel_code_t PSEL_DIV1 = 2'd0;
	localparam psel_code_t PSEL_HIGH = 2'd1;
	localparam psel_code_t PSEL_LOW  = 2'd2;

	localparam reg_idx_t REG_SERVO_MIN    = 3'd0;
	localparam reg_idx_t REG_SERVO_MAX    = 3'd1;
	localparam reg_idx_t REG_OFF_VALUE    = 3'd2;
	localparam reg_idx_t REG_TIMER_PERIOD = 3'd3;
	localparam reg_idx_t REG_SYNC_BYTE    = 3'd4;

	localparam word_t RST_SERVO_MIN    = 16'd3036;
	localparam word_t RST_SERVO_MAX    = 16'd3848;
	localparam word_t RST_OFF_VALUE    = 16'd3000;
	localparam word_t RST_TIMER_PERIOD = 16'h0FFF;
	localparam byte_t RST_SYNC_BYTE    = 8'd115;

	localparam frame_cnt_t FRAME_END = frame_cnt_t'(FRAME_LEN);
	localparam pdiv_t DIV_HIGH = pdiv_t'(HIGH_PRESCALE);
	localparam pdiv_t DIV_LOW  = pdiv_t'(LOW_PRESCALE);
	localparam pdiv_t DIV_ONE  = pdiv_t'(1);

	function automatic word_t clamp_position(word_t raw, word_t lo, word_t hi);
		logic signed [16:0] v;
		logic signed [16:0] lo_s;
		logic signed [16:0] hi_s;
		v    = signed'({raw[15], raw});
		lo_s = signed'({1'b0, lo});
		hi_s = signed'({1'b0, hi});
		if (v > hi_s) begin
			return hi;
		end else if (v < lo_s) begin
			return lo;
		end
		return raw;
	endfunction

endpackage

// File: hdl/framed_servo_pulse_generator.sv
// top level: serial-frame position capture and prescaled servo pulse timer
// output: the result of a transaction is registered at its accepting edge
// throughput: one input transaction per cycle; the single state update path sets this
// input is taken whenever the output register is empty or being drained in the same cycle
// reset: asynchronous, active low; registers except output data return to defaults
`include "framed_servo_pulse_generator_macros.svh"
module framed_servo_pulse_generator (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [fspg_pkg::ADDR_W-1:0] paddr,
	input  logic [fspg_pkg::DATA_W-1:0] pwdata,
	output logic [fspg_pkg::DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  opcode,
	input  logic [7:0]            rx_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  pulse_level,
	output logic [15:0]           position_value,
	output logic                  frame_complete
);
	import fspg_pkg::*;

	word_t servo_min_q, servo_max_q, off_value_q, timer_period_q;
	byte_t sync_byte_q;

	frame_idx_t frame_idx_q;
	byte_t      pos_high_q, pos_low_q;
	logic       line_q;
	word_t      timer_q;
	presc_t     presc_q;
	psel_code_t psel_q;

	logic       out_valid_q;
	logic       pulse_q;
	word_t      position_q;
	logic       done_q;

	reg_idx_t   reg_idx;
	logic       cfg_wr;
	logic       accept;

	frame_idx_t frame_idx_d;
	byte_t      pos_high_d, pos_low_d;
	logic       line_d;
	word_t      timer_d;
	presc_t     presc_d;
	psel_code_t psel_d;
	logic       done_d;
	word_t      clamped;
	frame_cnt_t frame_next;
	pdiv_t      presc_next;
	pdiv_t      divisor;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_SERVO_MIN:    prdata = DATA_W'(servo_min_q);
			REG_SERVO_MAX:    prdata = DATA_W'(servo_max_q);
			REG_OFF_VALUE:    prdata = DATA_W'(off_value_q);
			REG_TIMER_PERIOD: prdata = DATA_W'(timer_period_q);
			REG_SYNC_BYTE:    prdata = DATA_W'(sync_byte_q);
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			servo_min_q    <= RST_SERVO_MIN;
			servo_max_q    <= RST_SERVO_MAX;
			off_value_q    <= RST_OFF_VALUE;
			timer_period_q <= RST_TIMER_PERIOD;
			sync_byte_q    <= RST_SYNC_BYTE;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_SERVO_MIN:    servo_min_q    <= pwdata[15:0];
				REG_SERVO_MAX:    servo_max_q    <= pwdata[15:0];
				REG_OFF_VALUE:    off_value_q    <= pwdata[15:0];
				REG_TIMER_PERIOD: timer_period_q <= pwdata[15:0];
				REG_SYNC_BYTE:    sync_byte_q    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;

	always_comb begin
		unique case (psel_q)
			PSEL_HIGH: divisor = DIV_HIGH;
			PSEL_LOW:  divisor = DIV_LOW;
			default:   divisor = DIV_ONE;
		endcase
	end

	always_comb begin
		frame_idx_d = frame_idx_q;
		pos_high_d  = pos_high_q;
		pos_low_d   = pos_low_q;
		line_d      = line_q;
		timer_d     = timer_q;
		presc_d     = presc_q;
		psel_d      = psel_q;
		done_d      = 1'b0;
		frame_next  = {1'b0, frame_idx_q} + frame_cnt_t'(1);
		presc_next  = {1'b0, presc_q} + pdiv_t'(1);
		if (opcode == OP_BYTE) begin
			if (frame_idx_q == '0) begin
				if (rx_byte == sync_byte_q) begin
					frame_idx_d = frame_idx_t'(1);
				end
			end else begin
				if (frame_idx_q == frame_idx_t'(1)) begin
					pos_high_d = rx_byte;
				end else if (frame_idx_q == frame_idx_t'(2)) begin
					pos_low_d = rx_byte;
				end
				if (frame_next >= FRAME_END) begin
					frame_idx_d = '0;
					done_d      = 1'b1;
				end else begin
					frame_idx_d = frame_next[FRAME_W-1:0];
				end
			end
		end
		clamped = clamp_position({pos_high_d, pos_low_d}, servo_min_q, servo_max_q);
		if (opcode == OP_TICK) begin
			if (presc_next >= divisor) begin
				presc_d = '0;
				if (timer_q == timer_period_q) begin
					if (!line_q) begin
						line_d  = 1'b1;
						psel_d  = PSEL_HIGH;
						timer_d = clamped;
					end else begin
						line_d  = 1'b0;
						psel_d  = PSEL_LOW;
						timer_d = off_value_q;
					end
				end else begin
					timer_d = timer_q + 16'd1;
				end
			end else begin
				presc_d = presc_next[PRESC_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_idx_q <= '0;
			pos_high_q  <= '0;
			pos_low_q   <= '0;
			line_q      <= 1'b0;
			timer_q     <= '0;
			presc_q     <= '0;
			psel_q      <= PSEL_DIV1;
		end else if (accept) begin
			frame_idx_q <= frame_idx_d;
			pos_high_q  <= pos_high_d;
			pos_low_q   <= pos_low_d;
			line_q      <= line_d;
			timer_q     <= timer_d;
			presc_q     <= presc_d;
			psel_q      <= psel_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pulse_q    <= line_d;
			position_q <= clamped;
			done_q     <= done_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign pulse_level    = pulse_q;
	assign position_value = position_q;
	assign frame_complete = done_q;

	`FSPG_ASSERT(a_tick_no_frame_done, (accept && opcode == OP_TICK) |=> !frame_complete)
	`FSPG_ASSERT(a_empty_takes_input, !out_valid_q |-> in_ready)
	`FSPG_ASSERT(a_level_tracks_line, out_valid_q |-> (pulse_level == line_q))
	`FSPG_ASSERT_NEVER(a_presc_in_range, {1'b0, presc_q} >= divisor)
	`FSPG_ASSERT_NEVER(a_frame_in_range, {1'b0, frame_idx_q} >= FRAME_END)

endmodule

// File: sim/tb_framed_servo_pulse_generator.sv
// testbench for the framed servo pulse generator: predicted frame capture, clamp and pulse timer
module tb_framed_servo_pulse_generator;
	timeunit 1ns;
	timeprecision 1ps;

	import fspg_pkg::*;

	typedef struct packed {
		logic  pulse_level;
		word_t position_value;
		logic  frame_complete;
	} servo_sample_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              opcode = OP_BYTE;
	logic [7:0]        rx_byte = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              pulse_level;
	logic [15:0]       position_value;
	logic              frame_complete;

	framed_servo_pulse_generator DUT (.*);

	// predicted block state and register copies
	word_t      cfg_min = RST_SERVO_MIN;
	word_t      cfg_max = RST_SERVO_MAX;
	word_t      cfg_off = RST_OFF_VALUE;
	word_t      cfg_period = RST_TIMER_PERIOD;
	byte_t      cfg_sync = RST_SYNC_BYTE;
	int         frame_pos = 0;
	byte_t      pos_hi = '0;
	byte_t      pos_lo = '0;
	logic       line_hi = 1'b0;
	word_t      timer_val = '0;
	int         presc_cnt = 0;
	psel_code_t presc_code = PSEL_DIV1;

	servo_sample_t pending_samples[$];

	int  mismatches = 0;
	int  samples_seen = 0;
	int  frames_done = 0;
	int  line_edges = 0;
	int  timer_wraps = 0;
	int  reg_writes = 0;
	int  input_stalls = 0;
	bit  idle_on = 1'b1;
	int  hold_left = 0;
	int  run_left = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 4);
		end
		return $urandom_range(12, 40);
	endfunction

	function automatic word_t clamped_reload();
		logic signed [15:0] raw;
		int v;
		raw = {pos_hi, pos_lo};
		v = int'(raw);
		if (v > int'(cfg_max)) begin
			return cfg_max;
		end else if (v < int'(cfg_min)) begin
			return cfg_min;
		end
		return word_t'(raw);
	endfunction

	function automatic servo_sample_t advance_servo(logic op, byte_t b);
		servo_sample_t s;
		int div;
		s.frame_complete = 1'b0;
		if (op == OP_BYTE) begin
			if (frame_pos == 0) begin
				if (b == cfg_sync) begin
					frame_pos = 1;
				end
			end else begin
				if (frame_pos == 1) begin
					pos_hi = b;
				end else if (frame_pos == 2) begin
					pos_lo = b;
				end
				frame_pos++;
				if (frame_pos >= FRAME_LEN) begin
					frame_pos = 0;
					s.frame_complete = 1'b1;
					frames_done++;
				end
			end
		end else begin
			div = (presc_code == PSEL_HIGH) ? HIGH_PRESCALE :
				(presc_code == PSEL_LOW) ? LOW_PRESCALE : 1;
			if (presc_cnt + 1 >= div) begin
				presc_cnt = 0;
				if (timer_val == cfg_period) begin
					line_edges++;
					if (!line_hi) begin
						line_hi = 1'b1;
						presc_code = PSEL_HIGH;
						timer_val = clamped_reload();
					end else begin
						line_hi = 1'b0;
						presc_code = PSEL_LOW;
						timer_val = cfg_off;
					end
				end else begin
					if (timer_val == 16'hFFFF) begin
						timer_wraps++;
					end
					timer_val = timer_val + 16'd1;
				end
			end else begin
				presc_cnt++;
			end
		end
		s.pulse_level = line_hi;
		s.position_value = clamped_reload();
		return s;
	endfunction

	task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
		if (exp !== act) begin
			$display("%0t %s expected %0h actual %0h", $time, name, exp, act);
			mismatches++;
		end
	endtask

	// result checker
	always @(posedge clk) begin
		servo_sample_t exp;
		if (arst_n && out_valid && out_ready) begin
			samples_seen++;
			if (pending_samples.size() == 0) begin
				$display("%0t unexpected transaction: expected none actual %0h %0h %0h", $time,
					pulse_level, position_value, frame_complete);
				mismatches++;
			end else begin
				exp = pending_samples.pop_front();
				check_field("pulse_level", 32'(exp.pulse_level), 32'(pulse_level));
				check_field("position_value", 32'(exp.position_value), 32'(position_value));
				check_field("frame_complete", 32'(exp.frame_complete), 32'(frame_complete));
			end
		end
	end

	// receiver: random stalls, plus a long hold-off when requested
	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (!idle_on) begin
				out_ready <= 1'b1;
			end else if (run_left > 0) begin
				run_left--;
			end else begin
				out_ready <= ($urandom_range(0, 99) < 70);
				run_left = idle_length();
			end
		end
	end

	task automatic send_item(logic op, byte_t b);
		int gap;
		gap = idle_on ? idle_length() : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready) begin
			input_stalls++;
			@(posedge clk);
		end
		pending_samples.push_back(advance_servo(op, b));
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, word_t value);
		logic [DATA_W-1:0] readback;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= DATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_SERVO_MIN:    cfg_min = value;
			REG_SERVO_MAX:    cfg_max = value;
			REG_OFF_VALUE:    cfg_off = value;
			REG_TIMER_PERIOD: cfg_period = value;
			REG_SYNC_BYTE:    cfg_sync = value[7:0];
			default:          ;
		endcase
		reg_writes++;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		readback = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		check_field("register readback",
			(idx == REG_SYNC_BYTE) ? int'(value[7:0]) : int'(value), readback);
	endtask

	// mixed traffic: mostly well-formed frames with random content, some noise and ticks
	task automatic random_traffic(int count, int tick_pct);
		int done_items;
		int r;
		logic op;
		byte_t b;
		bit ignored;
		done_items = 0;
		while (done_items < count) begin
			if (done_items % 150 == 0) begin
				idle_on = ($urandom_range(0, 3) != 0);
			end
			r = $urandom_range(0, 99);
			op = OP_BYTE;
			if (r < tick_pct) begin
				op = OP_TICK;
				b = byte_t'($urandom_range(0, 255));
			end else if (r < tick_pct + 4 || (frame_pos == 0 && $urandom_range(0, 9) == 0)) begin
				b = byte_t'($urandom_range(0, 255));
			end else if (frame_pos == 0) begin
				b = cfg_sync;
			end else begin
				r = $urandom_range(0, 7);
				if (r == 0) begin
					b = cfg_sync;
				end else if (r == 1) begin
					case ($urandom_range(0, 3))
						0:       b = 8'h00;
						1:       b = 8'h7F;
						2:       b = 8'h80;
						default: b = 8'hFF;
					endcase
				end else begin
					b = byte_t'($urandom_range(0, 255));
				end
			end
			ignored = (op == OP_BYTE) && (frame_pos == 0) && (b != cfg_sync);
			send_item(op, b);
			if (!ignored) begin
				done_items++;
			end
		end
		idle_on = 1'b1;
	endtask

	task automatic test_reset_and_frame();
		send_item(OP_BYTE, 8'h00);
		send_item(OP_BYTE, 8'hFF);
		send_item(OP_TICK, 8'hFF);
		send_item(OP_BYTE, cfg_sync);
		// high byte alone gives a negative mix with the old low byte
		send_item(OP_BYTE, 8'h80);
		send_item(OP_BYTE, 8'h00);
		send_item(OP_BYTE, cfg_sync);
		send_item(OP_BYTE, 8'hFF);
		while (frame_pos != 0) send_item(OP_BYTE, byte_t'($urandom_range(0, 255)));
		send_item(OP_BYTE, 8'h01);
	endtask

	// period 1 keeps whole pulse cycles short
	task automatic test_fast_pulse();
		drain_results();
		write_reg(REG_TIMER_PERIOD, 16'd1);
		write_reg(REG_OFF_VALUE, 16'd0);
		write_reg(REG_SERVO_MIN, 16'd1);
		write_reg(REG_SERVO_MAX, 16'd1);
		random_traffic(250, 60);
	endtask

	task automatic test_pulse_window();
		drain_results();
		write_reg(REG_TIMER_PERIOD, 16'd24);
		write_reg(REG_OFF_VALUE, 16'd20);
		write_reg(REG_SERVO_MIN, 16'd4);
		write_reg(REG_SERVO_MAX, 16'd12);
		write_reg(REG_SYNC_BYTE, 16'h00A5);
		random_traffic(250, 70);
	endtask

	task automatic test_backpressure();
		hold_left = 80;
		random_traffic(40, 50);
		drain_results();
	endtask

	// on-phase reload above the period forces the timer through its wrap
	task automatic test_reload_wrap();
		int start_wraps;
		drain_results();
		write_reg(REG_SERVO_MIN, 16'd65532);
		write_reg(REG_SERVO_MAX, 16'd65535);
		start_wraps = timer_wraps;
		random_traffic(300, 85);
		while (timer_wraps == start_wraps) send_item(OP_TICK, byte_t'($urandom_range(0, 255)));
	endtask

	task automatic test_crossed_clamp();
		drain_results();
		write_reg(REG_SERVO_MIN, 16'd5000);
		write_reg(REG_SERVO_MAX, 16'd1000);
		write_reg(REG_SYNC_BYTE, 16'h0000);
		random_traffic(120, 0);
	endtask

	task automatic test_clamp_extremes();
		drain_results();
		write_reg(REG_SERVO_MIN, 16'd0);
		write_reg(REG_SERVO_MAX, 16'hFFFF);
		write_reg(REG_SYNC_BYTE, 16'h00FF);
		random_traffic(60, 0);
		drain_results();
		write_reg(REG_SERVO_MIN, 16'hFFFF);
		write_reg(REG_SERVO_MAX, 16'd0);
		random_traffic(60, 0);
	endtask

	task automatic test_long_period();
		drain_results();
		write_reg(REG_TIMER_PERIOD, 16'hFFFF);
		write_reg(REG_OFF_VALUE, 16'hFFFF);
		random_traffic(80, 50);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_and_frame();
		test_fast_pulse();
		test_pulse_window();
		test_backpressure();
		test_reload_wrap();
		test_crossed_clamp();
		test_clamp_extremes();
		test_long_period();
		drain_results();
		repeat (10) @(posedge clk);
		$display("run covered %0d transactions checked, %0d frames, %0d line edges",
			samples_seen, frames_done, line_edges);
		$display("%0d timer wraps, %0d register writes, %0d cycles with input held off",
			timer_wraps, reg_writes, input_stalls);
		if (mismatches == 0 && pending_samples.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+hdl
hdl/fspg_pkg.sv
hdl/framed_servo_pulse_generator.sv
sim/tb_framed_servo_pulse_generator.sv
